@@ design/scs1kd_pkg.sv @@
// Package for the scan code set 1 key decoder.
// Holds the prefix state type, the decoder state and result structs, the scan code
// constants and the key lookup tables. No dependencies.
package scs1kd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_E0        = 3'd1,
		ST_E02A      = 3'd2,
		ST_E0AA      = 3'd3,
		ST_E1        = 3'd4,
		ST_AFTER_REL = 3'd5,
		ST_DROP      = 3'd6
	} prefix_t;

	typedef struct packed {
		logic       shift;
		logic       alt;
		logic       ctrl;
		logic       caps;
		logic       num;
		logic       scroll;
		prefix_t    prefix;
		logic [2:0] skip;
	} kbd_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       not_ascii;
		logic       keypad;
		logic       extended;
		logic       shift_held;
		logic       alt_held;
		logic       ctrl_held;
		logic [2:0] led_mask;
	} result_t;

	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_LED = 1'b1;

	localparam logic [7:0] CODE_E0         = 8'd224;
	localparam logic [7:0] CODE_E1         = 8'd225;
	localparam logic [7:0] CODE_PAD_ENTER  = 8'd28;
	localparam logic [7:0] CODE_CTRL       = 8'd29;
	localparam logic [7:0] CODE_LSHIFT     = 8'd42;
	localparam logic [7:0] CODE_PAD_SLASH  = 8'd53;
	localparam logic [7:0] CODE_RSHIFT     = 8'd54;
	localparam logic [7:0] CODE_PAD_STAR   = 8'd55;
	localparam logic [7:0] CODE_ALT        = 8'd56;
	localparam logic [7:0] CODE_CAPS       = 8'd58;
	localparam logic [7:0] CODE_F1         = 8'd59;
	localparam logic [7:0] CODE_F10        = 8'd68;
	localparam logic [7:0] CODE_NUM        = 8'd69;
	localparam logic [7:0] CODE_SCROLL     = 8'd70;
	localparam logic [7:0] CODE_PAD_FIRST  = 8'd71;
	localparam logic [7:0] CODE_PAD_DEL    = 8'd83;
	localparam logic [7:0] CODE_F11        = 8'd87;
	localparam logic [7:0] CODE_F12        = 8'd88;
	localparam logic [7:0] REL_CTRL        = 8'd157;
	localparam logic [7:0] REL_LSHIFT      = 8'd170;
	localparam logic [7:0] REL_RSHIFT      = 8'd182;
	localparam logic [7:0] REL_ALT         = 8'd184;

	localparam logic [7:0] VAL_CR    = 8'd13;
	localparam logic [7:0] VAL_SLASH = 8'd47;
	localparam logic [7:0] VAL_DEL   = 8'd127;
	localparam logic [7:0] VAL_PAUSE = 8'd69;
	localparam logic [7:0] CTRL_MAX  = 8'd31;

	localparam int TAB_LEN = 52;
	localparam int PAD_LEN = 14;
	localparam logic [2:0] E1_SKIP   = 3'd4;
	localparam logic [2:0] E0X_SKIP  = 3'd1;

	localparam logic [7:0] PLAIN_TAB [TAB_LEN] = '{
		8'd27, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48,
		8'd45, 8'd61, 8'd8, 8'd9, 8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121,
		8'd117, 8'd105, 8'd111, 8'd112, 8'd91, 8'd93, 8'd13, 8'd97, 8'd115, 8'd100,
		8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd59, 8'd39, 8'd96, 8'd92,
		8'd122, 8'd120, 8'd99, 8'd118, 8'd98, 8'd110, 8'd109, 8'd44, 8'd46, 8'd47,
		8'd32};

	localparam logic [7:0] SHIFT_TAB [TAB_LEN] = '{
		8'd27, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42, 8'd40, 8'd41,
		8'd95, 8'd43, 8'd8, 8'd9, 8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89,
		8'd85, 8'd73, 8'd79, 8'd80, 8'd123, 8'd125, 8'd10, 8'd65, 8'd83, 8'd68,
		8'd70, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76, 8'd58, 8'd34, 8'd126, 8'd124,
		8'd90, 8'd88, 8'd67, 8'd86, 8'd66, 8'd78, 8'd77, 8'd60, 8'd62, 8'd63,
		8'd32};

	localparam logic [7:0] CTRL_TAB [TAB_LEN] = '{
		8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd30, 8'd39, 8'd40, 8'd41, 8'd42,
		8'd31, 8'd43, 8'd44, 8'd45, 8'd17, 8'd23, 8'd5, 8'd18, 8'd20, 8'd25,
		8'd21, 8'd9, 8'd15, 8'd16, 8'd27, 8'd29, 8'd46, 8'd1, 8'd19, 8'd4,
		8'd6, 8'd7, 8'd8, 8'd10, 8'd11, 8'd12, 8'd47, 8'd48, 8'd49, 8'd28,
		8'd26, 8'd24, 8'd3, 8'd22, 8'd2, 8'd14, 8'd13, 8'd50, 8'd51, 8'd52,
		8'd53};

	localparam logic [7:0] PAD_TAB [PAD_LEN] = '{
		8'd42, 8'd71, 8'd72, 8'd73, 8'd45, 8'd75, 8'd53, 8'd77, 8'd43, 8'd79, 8'd80,
		8'd81, 8'd82, 8'd127};

	localparam logic [7:0] PAD_SHIFT_TAB [PAD_LEN] = '{
		8'd42, 8'd55, 8'd56, 8'd57, 8'd45, 8'd52, 8'd53, 8'd54, 8'd43, 8'd49, 8'd50,
		8'd51, 8'd48, 8'd46};

	localparam logic [7:0] PAD_CTRL_TAB [PAD_LEN] = '{
		8'd55, 8'd39, 8'd40, 8'd41, 8'd56, 8'd36, 8'd37, 8'd57, 8'd43, 8'd33, 8'd34,
		8'd35, 8'd42, 8'd52};

	// Keypad entries that are ASCII characters rather than key codes.
	function automatic logic pad_is_ascii(input logic [3:0] idx);
		return (idx == 4'd0) || (idx == 4'd4) || (idx == 4'd6) || (idx == 4'd8) ||
			(idx == 4'd13);
	endfunction

	function automatic result_t make_key(input logic [7:0] value, input logic na,
		input logic kp, input logic ext, input kbd_state_t st);
		result_t r;
		r = '0;
		r.kind       = KIND_KEY;
		r.value      = value;
		r.not_ascii  = na;
		r.keypad     = kp;
		r.extended   = ext;
		r.shift_held = st.shift;
		r.alt_held   = st.alt;
		r.ctrl_held  = st.ctrl;
		return r;
	endfunction

	function automatic result_t make_led(input kbd_state_t st);
		result_t r;
		r = '0;
		r.kind     = KIND_LED;
		r.led_mask = {st.caps, st.num, st.scroll};
		return r;
	endfunction

endpackage

@@ design/scs1kd_decode.sv @@
// Combinational decode of one scan code byte against the current keyboard state.
// Produces the next state and at most one result. Depends on scs1kd_pkg.
module scs1kd_decode import scs1kd_pkg::*; (
	input  kbd_state_t cur,
	input  logic [7:0] code,
	output kbd_state_t nxt,
	output logic       emit,
	output result_t    res
);

	kbd_state_t i_nxt;
	logic       i_emit;
	result_t    i_res;
	logic [3:0] pidx;
	logic [6:0] tidx;
	logic [7:0] v;

	// Plain key decoding, shared by the idle state and the byte after an extended release.
	always_comb begin
		i_nxt = cur;
		i_nxt.prefix = ST_IDLE;
		i_emit = 1'b0;
		i_res = '0;
		v = '0;
		pidx = (code == CODE_PAD_STAR) ? 4'd0 : 4'(code - 8'd70);
		if (code > CODE_PAD_DEL) begin
			tidx = 7'(code - 8'd10);
		end else if (code > CODE_ALT) begin
			tidx = 7'(code - 8'd6);
		end else if (code > CODE_LSHIFT) begin
			tidx = 7'(code - 8'd3);
		end else if (code > CODE_CTRL) begin
			tidx = 7'(code - 8'd2);
		end else begin
			tidx = 7'(code - 8'd1);
		end
		if (code == 8'd0) begin
			i_emit = 1'b0;
		end else if (code == CODE_E0) begin
			i_nxt.prefix = ST_E0;
		end else if (code == CODE_E1) begin
			i_nxt.prefix = ST_E1;
			i_nxt.skip = E1_SKIP;
		end else if (code[7]) begin
			if (code == REL_CTRL) begin
				i_nxt.ctrl = 1'b0;
			end else if (code == REL_LSHIFT || code == REL_RSHIFT) begin
				i_nxt.shift = 1'b0;
			end else if (code == REL_ALT) begin
				i_nxt.alt = 1'b0;
			end
		end else if (code == CODE_CTRL) begin
			i_nxt.ctrl = 1'b1;
		end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
			i_nxt.shift = 1'b1;
		end else if (code == CODE_ALT) begin
			i_nxt.alt = 1'b1;
		end else if (code == CODE_CAPS) begin
			i_nxt.caps = !cur.caps;
			i_emit = 1'b1;
			i_res = make_led(i_nxt);
		end else if (code == CODE_PAD_STAR || (code >= CODE_PAD_FIRST && code <= CODE_PAD_DEL))
		begin
			i_emit = 1'b1;
			if (cur.alt) begin
				i_res = make_key({4'd0, pidx}, 1'b1, 1'b1, 1'b0, cur);
			end else if (cur.ctrl) begin
				i_res = make_key(PAD_CTRL_TAB[pidx], 1'b1, 1'b1, 1'b0, cur);
			end else if (cur.shift == cur.num) begin
				i_res = make_key(PAD_TAB[pidx], !pad_is_ascii(pidx), 1'b1, 1'b0, cur);
			end else begin
				i_res = make_key(PAD_SHIFT_TAB[pidx], 1'b0, 1'b1, 1'b0, cur);
			end
		end else if ((code >= CODE_F1 && code <= CODE_F10) || code == CODE_F11 ||
			code == CODE_F12) begin
			i_emit = 1'b1;
			i_res = make_key(code, 1'b1, 1'b0, 1'b0, cur);
		end else if (code == CODE_NUM) begin
			i_nxt.num = !cur.num;
			i_emit = 1'b1;
			i_res = make_led(i_nxt);
		end else if (code == CODE_SCROLL) begin
			i_nxt.scroll = !cur.scroll;
			i_emit = 1'b1;
			i_res = make_led(i_nxt);
		end else if (tidx < 7'(TAB_LEN)) begin
			i_emit = 1'b1;
			if (cur.alt) begin
				i_res = make_key({1'b0, tidx}, 1'b1, 1'b0, 1'b0, cur);
			end else if (cur.ctrl) begin
				v = CTRL_TAB[tidx[5:0]];
				i_res = make_key(v, v > CTRL_MAX, 1'b0, 1'b0, cur);
			end else if (cur.shift) begin
				v = SHIFT_TAB[tidx[5:0]];
				if (cur.caps && ((v >= 8'd65 && v <= 8'd90) || (v >= 8'd97 && v <= 8'd122)))
				begin
					v[5] = !v[5];
				end
				i_res = make_key(v, 1'b0, 1'b0, 1'b0, cur);
			end else begin
				v = PLAIN_TAB[tidx[5:0]];
				if (cur.caps && v >= 8'd97 && v <= 8'd122) begin
					v[5] = 1'b0;
				end
				i_res = make_key(v, 1'b0, 1'b0, 1'b0, cur);
			end
		end
	end

	always_comb begin
		nxt = cur;
		emit = 1'b0;
		res = '0;
		unique case (cur.prefix)
			ST_E0: begin
				nxt.prefix = ST_IDLE;
				if (code[7]) begin
					if (code == REL_LSHIFT) begin
						nxt.prefix = ST_E0AA;
						nxt.skip = E0X_SKIP;
					end else begin
						if (code == REL_CTRL) begin
							nxt.ctrl = 1'b0;
						end else if (code == REL_ALT) begin
							nxt.alt = 1'b0;
						end
						nxt.prefix = ST_AFTER_REL;
					end
				end else if (code == CODE_LSHIFT) begin
					nxt.prefix = ST_E02A;
					nxt.skip = E0X_SKIP;
				end else if (code == CODE_CTRL) begin
					nxt.ctrl = 1'b1;
				end else if (code == CODE_ALT) begin
					nxt.alt = 1'b1;
				end else if (code == CODE_PAD_ENTER) begin
					emit = 1'b1;
					res = make_key(VAL_CR, 1'b0, 1'b1, 1'b0, cur);
				end else if (code == CODE_PAD_SLASH) begin
					emit = 1'b1;
					res = make_key(VAL_SLASH, 1'b0, 1'b1, 1'b0, cur);
				end else if (code == CODE_PAD_DEL) begin
					emit = 1'b1;
					res = make_key(VAL_DEL, 1'b0, 1'b0, 1'b1, cur);
				end else if (code != CODE_SCROLL) begin
					emit = 1'b1;
					res = make_key(code, 1'b1, 1'b0, 1'b1, cur);
				end
			end
			ST_E02A, ST_E0AA: begin
				if (cur.skip != 3'd0) begin
					nxt.skip = cur.skip - 3'd1;
				end else begin
					nxt.prefix = ST_IDLE;
					emit = 1'b1;
					if (cur.prefix == ST_E02A && code == CODE_PAD_DEL) begin
						res = make_key(VAL_DEL, 1'b0, 1'b0, 1'b1, cur);
					end else begin
						res = make_key(code, 1'b1, 1'b0, 1'b1, cur);
					end
				end
			end
			ST_E1: begin
				if (cur.skip != 3'd0) begin
					nxt.skip = cur.skip - 3'd1;
				end else begin
					nxt.prefix = ST_IDLE;
					emit = 1'b1;
					res = make_key(VAL_PAUSE, 1'b1, 1'b0, 1'b1, cur);
				end
			end
			ST_AFTER_REL: begin
				if (code == CODE_E0) begin
					nxt.prefix = ST_DROP;
				end else begin
					nxt = i_nxt;
					emit = i_emit;
					res = i_res;
				end
			end
			ST_DROP: begin
				nxt.prefix = ST_IDLE;
			end
			default: begin
				nxt = i_nxt;
				emit = i_emit;
				res = i_res;
			end
		endcase
	end

endmodule

@@ design/scancode_set1_key_decoder.sv @@
// A byte accepted into the input register is decoded against the state register; its result,
// if any, is registered in the result register and presented on the master side from there.
// Throughput: one byte per cycle unless a held result with m_tready low stalls the input stage.
// Reset (arst_n low, asynchronous): modifiers and caps and scroll lock off,
// num lock on, no prefix pending, both pipeline registers empty.
// Top level: input register, state register and result register around scs1kd_decode.
module scancode_set1_key_decoder import scs1kd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] scancode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] value, [8] not_ascii, [9] keypad, [10] extended,
	                              // [11] shift_held, [12] alt_held, [13] ctrl_held,
	                              // [16:14] led_mask, [23:17] zero
	output logic        m_tuser   // [0] kind
);

	logic       valid_s1;
	logic [7:0] code_s1;
	kbd_state_t state_q;
	kbd_state_t nxt;
	logic       emit;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;
	logic       advance;

	scs1kd_decode u_decode (
		.cur  (state_q),
		.code (code_s1),
		.nxt  (nxt),
		.emit (emit),
		.res  (res)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{shift: 1'b0, alt: 1'b0, ctrl: 1'b0, caps: 1'b0, num: 1'b1,
				scroll: 1'b0, prefix: ST_IDLE, skip: 3'd0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q     <= nxt;
				out_valid_q <= emit;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= s_tdata;
		end
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {7'd0, out_q.led_mask, out_q.ctrl_held, out_q.alt_held,
		out_q.shift_held, out_q.extended, out_q.keypad, out_q.not_ascii, out_q.value};

`ifndef NO_ASSERTIONS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(code_s1))
		else $error("input stage lost or changed a stalled byte");

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.skip <= E1_SKIP)
		else $error("skip counter out of range");

	a_led_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_LED |-> m_tdata[13:0] == 14'd0)
		else $error("LED result carries key fields");

	a_key_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_KEY |-> m_tdata[16:14] == 3'd0)
		else $error("key result carries an LED mask");
`endif

endmodule

@@ dv/scs1kd_checker.sv @@
`timescale 1ns / 1ps
// Checker for scancode_set1_key_decoder: follows both stream channels, decodes each accepted
// scan code with its own keyboard model and compares the key words and LED updates.
// Depends on scs1kd_pkg for the prefix and result types and the scan code constants.
module scs1kd_checker import scs1kd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          words_due
);

	localparam logic [7:0] KEYS_PLAIN [TAB_LEN] = '{
		8'd27, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48, 8'd45,
		8'd61, 8'd8, 8'd9, 8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105,
		8'd111, 8'd112, 8'd91, 8'd93, 8'd13, 8'd97, 8'd115, 8'd100, 8'd102, 8'd103, 8'd104,
		8'd106, 8'd107, 8'd108, 8'd59, 8'd39, 8'd96, 8'd92, 8'd122, 8'd120, 8'd99, 8'd118,
		8'd98, 8'd110, 8'd109, 8'd44, 8'd46, 8'd47, 8'd32};

	localparam logic [7:0] KEYS_SHIFT [TAB_LEN] = '{
		8'd27, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42, 8'd40, 8'd41, 8'd95,
		8'd43, 8'd8, 8'd9, 8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89, 8'd85, 8'd73,
		8'd79, 8'd80, 8'd123, 8'd125, 8'd10, 8'd65, 8'd83, 8'd68, 8'd70, 8'd71, 8'd72,
		8'd74, 8'd75, 8'd76, 8'd58, 8'd34, 8'd126, 8'd124, 8'd90, 8'd88, 8'd67, 8'd86,
		8'd66, 8'd78, 8'd77, 8'd60, 8'd62, 8'd63, 8'd32};

	localparam logic [7:0] KEYS_CTRL [TAB_LEN] = '{
		8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd30, 8'd39, 8'd40, 8'd41, 8'd42, 8'd31,
		8'd43, 8'd44, 8'd45, 8'd17, 8'd23, 8'd5, 8'd18, 8'd20, 8'd25, 8'd21, 8'd9,
		8'd15, 8'd16, 8'd27, 8'd29, 8'd46, 8'd1, 8'd19, 8'd4, 8'd6, 8'd7, 8'd8,
		8'd10, 8'd11, 8'd12, 8'd47, 8'd48, 8'd49, 8'd28, 8'd26, 8'd24, 8'd3, 8'd22,
		8'd2, 8'd14, 8'd13, 8'd50, 8'd51, 8'd52, 8'd53};

	localparam logic [7:0] PAD_NAV [PAD_LEN] = '{
		8'd42, 8'd71, 8'd72, 8'd73, 8'd45, 8'd75, 8'd53, 8'd77, 8'd43, 8'd79, 8'd80,
		8'd81, 8'd82, 8'd127};

	localparam logic [7:0] PAD_DIGIT [PAD_LEN] = '{
		8'd42, 8'd55, 8'd56, 8'd57, 8'd45, 8'd52, 8'd53, 8'd54, 8'd43, 8'd49, 8'd50,
		8'd51, 8'd48, 8'd46};

	localparam logic [7:0] PAD_CTRL_KEYS [PAD_LEN] = '{
		8'd55, 8'd39, 8'd40, 8'd41, 8'd56, 8'd36, 8'd37, 8'd57, 8'd43, 8'd33, 8'd34,
		8'd35, 8'd42, 8'd52};

	localparam logic [7:0] CASE_BIT = 8'h20;

	logic       shift_dn, alt_dn, ctrl_dn;
	logic       caps_lk, num_lk, scroll_lk;
	prefix_t    pfx;
	logic [2:0] skip_left;
	result_t    words [$];

	function automatic logic pad_is_char(input logic [7:0] idx);
		return idx == 8'd0 || idx == 8'd4 || idx == 8'd6 || idx == 8'd8 || idx == 8'd13;
	endfunction

	function automatic result_t key_word(input logic [7:0] v, input logic na, input logic kp,
		input logic ext);
		result_t w;
		w = '0;
		w.kind       = KIND_KEY;
		w.value      = v;
		w.not_ascii  = na;
		w.keypad     = kp;
		w.extended   = ext;
		w.shift_held = shift_dn;
		w.alt_held   = alt_dn;
		w.ctrl_held  = ctrl_dn;
		return w;
	endfunction

	function automatic result_t led_word();
		result_t w;
		w = '0;
		w.kind     = KIND_LED;
		w.led_mask = {caps_lk, num_lk, scroll_lk};
		return w;
	endfunction

	function automatic string show(input result_t w);
		return $sformatf("kind %0d value %0d na %0d kp %0d ext %0d sh %0d alt %0d ctl %0d led %0d",
			w.kind, w.value, w.not_ascii, w.keypad, w.extended, w.shift_held, w.alt_held,
			w.ctrl_held, w.led_mask);
	endfunction

	task automatic decode_plain(input logic [7:0] code, output bit got, output result_t w);
		logic [7:0] idx;
		logic [7:0] v;
		got = 1'b0;
		w = '0;
		idx = '0;
		v = '0;
		if (code == 8'd0) begin
		end else if (code == CODE_E0) begin
			pfx = ST_E0;
		end else if (code == CODE_E1) begin
			pfx = ST_E1;
			skip_left = E1_SKIP;
		end else if (code[7]) begin
			if (code == REL_CTRL)
				ctrl_dn = 1'b0;
			else if (code == REL_LSHIFT || code == REL_RSHIFT)
				shift_dn = 1'b0;
			else if (code == REL_ALT)
				alt_dn = 1'b0;
		end else if (code == CODE_CTRL) begin
			ctrl_dn = 1'b1;
		end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
			shift_dn = 1'b1;
		end else if (code == CODE_ALT) begin
			alt_dn = 1'b1;
		end else if (code == CODE_CAPS) begin
			caps_lk = !caps_lk;
			got = 1'b1;
			w = led_word();
		end else if (code == CODE_PAD_STAR || (code >= CODE_PAD_FIRST && code <= CODE_PAD_DEL)) begin
			idx = (code == CODE_PAD_STAR) ? 8'd0 : code - CODE_SCROLL;
			got = 1'b1;
			if (alt_dn)
				w = key_word(idx, 1'b1, 1'b1, 1'b0);
			else if (ctrl_dn)
				w = key_word(PAD_CTRL_KEYS[idx], 1'b1, 1'b1, 1'b0);
			else if (shift_dn == num_lk)
				w = key_word(PAD_NAV[idx], !pad_is_char(idx), 1'b1, 1'b0);
			else
				w = key_word(PAD_DIGIT[idx], 1'b0, 1'b1, 1'b0);
		end else if ((code >= CODE_F1 && code <= CODE_F10) || code == CODE_F11 ||
			code == CODE_F12) begin
			got = 1'b1;
			w = key_word(code, 1'b1, 1'b0, 1'b0);
		end else if (code == CODE_NUM) begin
			num_lk = !num_lk;
			got = 1'b1;
			w = led_word();
		end else if (code == CODE_SCROLL) begin
			scroll_lk = !scroll_lk;
			got = 1'b1;
			w = led_word();
		end else begin
			// Squeeze out the gaps that the modifier and lock keys leave in the code space.
			if (code > CODE_SCROLL)
				idx = code - 8'd10;
			else if (code > CODE_ALT)
				idx = code - 8'd6;
			else if (code > CODE_LSHIFT)
				idx = code - 8'd3;
			else if (code > CODE_CTRL)
				idx = code - 8'd2;
			else
				idx = code - 8'd1;
			if (idx < TAB_LEN) begin
				got = 1'b1;
				if (alt_dn) begin
					w = key_word(idx, 1'b1, 1'b0, 1'b0);
				end else if (ctrl_dn) begin
					v = KEYS_CTRL[idx];
					w = key_word(v, v > CTRL_MAX, 1'b0, 1'b0);
				end else if (shift_dn) begin
					v = KEYS_SHIFT[idx];
					if (caps_lk && ((v >= "A" && v <= "Z") || (v >= "a" && v <= "z")))
						v = v ^ CASE_BIT;
					w = key_word(v, 1'b0, 1'b0, 1'b0);
				end else begin
					v = KEYS_PLAIN[idx];
					if (caps_lk && v >= "a" && v <= "z")
						v = v ^ CASE_BIT;
					w = key_word(v, 1'b0, 1'b0, 1'b0);
				end
			end
		end
	endtask

	task automatic decode_e0(input logic [7:0] code, output bit got, output result_t w);
		got = 1'b0;
		w = '0;
		pfx = ST_IDLE;
		if (code[7]) begin
			if (code == REL_LSHIFT) begin
				pfx = ST_E0AA;
				skip_left = E0X_SKIP;
			end else begin
				if (code == REL_CTRL)
					ctrl_dn = 1'b0;
				else if (code == REL_ALT)
					alt_dn = 1'b0;
				pfx = ST_AFTER_REL;
			end
		end else if (code == CODE_LSHIFT) begin
			pfx = ST_E02A;
			skip_left = E0X_SKIP;
		end else if (code == CODE_CTRL) begin
			ctrl_dn = 1'b1;
		end else if (code == CODE_ALT) begin
			alt_dn = 1'b1;
		end else if (code == CODE_PAD_ENTER) begin
			got = 1'b1;
			w = key_word(VAL_CR, 1'b0, 1'b1, 1'b0);
		end else if (code == CODE_PAD_SLASH) begin
			got = 1'b1;
			w = key_word(VAL_SLASH, 1'b0, 1'b1, 1'b0);
		end else if (code == CODE_SCROLL) begin
			// The break half of Ctrl-Break is swallowed.
		end else if (code == CODE_PAD_DEL) begin
			got = 1'b1;
			w = key_word(VAL_DEL, 1'b0, 1'b0, 1'b1);
		end else begin
			got = 1'b1;
			w = key_word(code, 1'b1, 1'b0, 1'b1);
		end
	endtask

	task automatic decode_scancode(input logic [7:0] code, output bit got, output result_t w);
		got = 1'b0;
		w = '0;
		case (pfx)
			ST_E0: begin
				decode_e0(code, got, w);
			end
			ST_E02A, ST_E0AA: begin
				if (skip_left != 3'd0) begin
					skip_left--;
				end else begin
					got = 1'b1;
					if (pfx == ST_E02A && code == CODE_PAD_DEL)
						w = key_word(VAL_DEL, 1'b0, 1'b0, 1'b1);
					else
						w = key_word(code, 1'b1, 1'b0, 1'b1);
					pfx = ST_IDLE;
				end
			end
			ST_E1: begin
				if (skip_left != 3'd0) begin
					skip_left--;
				end else begin
					pfx = ST_IDLE;
					got = 1'b1;
					w = key_word(VAL_PAUSE, 1'b1, 1'b0, 1'b1);
				end
			end
			ST_AFTER_REL: begin
				if (code == CODE_E0) begin
					pfx = ST_DROP;
				end else begin
					pfx = ST_IDLE;
					decode_plain(code, got, w);
				end
			end
			ST_DROP: begin
				pfx = ST_IDLE;
			end
			default: begin
				pfx = ST_IDLE;
				skip_left = 3'd0;
				decode_plain(code, got, w);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t seen;
		bit      got;
		if (!arst_n) begin
			shift_dn  = 1'b0;
			alt_dn    = 1'b0;
			ctrl_dn   = 1'b0;
			caps_lk   = 1'b0;
			num_lk    = 1'b1;
			scroll_lk = 1'b0;
			pfx       = ST_IDLE;
			skip_left = 3'd0;
			words.delete();
			errors    <= 0;
			words_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen            = '0;
				seen.kind       = m_tuser;
				seen.value      = m_tdata[7:0];
				seen.not_ascii  = m_tdata[8];
				seen.keypad     = m_tdata[9];
				seen.extended   = m_tdata[10];
				seen.shift_held = m_tdata[11];
				seen.alt_held   = m_tdata[12];
				seen.ctrl_held  = m_tdata[13];
				seen.led_mask   = m_tdata[16:14];
				if (words.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing outstanding: %s", $time, show(seen));
					errors <= errors + 1;
				end else begin
					want = words.pop_front();
					if (seen !== want) begin
						if (errors < 10)
							$display("%0t: mismatch, expected %s, got %s", $time, show(want),
								show(seen));
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				decode_scancode(s_tdata, got, want);
				if (got)
					words.push_back(want);
			end
			words_due <= words.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the scancode_set1_key_decoder testbench: clock, reset, scan code stimulus in bursts
// and output back-pressure; scs1kd_checker does the checking. Depends on scs1kd_pkg.
module tb_top import scs1kd_pkg::*;;

	localparam int ITEM_TARGET = 1900;
	localparam int IDLE_LIMIT  = 2000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	localparam logic [7:0] OPENING [34] = '{
		8'h00, 8'h1E, CODE_CAPS, CODE_LSHIFT, 8'h10, REL_LSHIFT, CODE_CTRL, 8'h1E, REL_CTRL,
		CODE_ALT, 8'h39, REL_ALT, 8'h4F, CODE_NUM, 8'h4F, CODE_SCROLL, CODE_F11, 8'h7F, 8'hFF,
		CODE_E0, CODE_PAD_ENTER, CODE_E0, 8'hC8, CODE_E0, 8'h11, CODE_E0, CODE_LSHIFT, 8'h00,
		CODE_PAD_DEL, CODE_E1, CODE_CTRL, CODE_NUM, CODE_E1, REL_CTRL};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;

	int       errors;
	int       words_due;
	int       items_sent = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	scancode_set1_key_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	scs1kd_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.words_due (words_due)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic send_code(input logic [7:0] code);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(32, 400);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
				default:   m_tready <= (rx_left % 5 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("scancode_set1_key_decoder test failed");
			$finish;
		end
	end

	initial begin
		int         pick;
		logic [7:0] code;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[i])
			send_code(OPENING[i]);
		send_code(8'h19);
		send_code(8'h23);
		send_code(8'h45);
		send_code(8'h21);
		send_code(8'h81);

		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				code = 8'($urandom_range(1, 88));
				send_code(code);
				if ($urandom_range(0, 1) == 1)
					send_code(code | 8'h80);
			end else if (pick < 50) begin
				case ($urandom_range(0, 3))
					0:       code = CODE_LSHIFT;
					1:       code = CODE_RSHIFT;
					2:       code = CODE_CTRL;
					default: code = CODE_ALT;
				endcase
				send_code(($urandom_range(0, 1) == 1) ? (code | 8'h80) : code);
			end else if (pick < 55) begin
				case ($urandom_range(0, 2))
					0:       send_code(CODE_CAPS);
					1:       send_code(CODE_NUM);
					default: send_code(CODE_SCROLL);
				endcase
			end else if (pick < 70) begin
				send_code(CODE_E0);
				code = 8'($urandom_range(0, 255));
				send_code(code);
				if (code[7] && code != REL_LSHIFT && $urandom_range(0, 2) == 0) begin
					send_code(CODE_E0);
					send_code(8'($urandom_range(0, 255)));
				end
			end else if (pick < 78) begin
				send_code(CODE_E0);
				send_code(($urandom_range(0, 1) == 1) ? CODE_LSHIFT : REL_LSHIFT);
				send_code(8'($urandom_range(0, 255)));
				send_code(($urandom_range(0, 1) == 1) ? CODE_PAD_DEL :
					8'($urandom_range(0, 255)));
			end else if (pick < 83) begin
				send_code(CODE_E1);
				if ($urandom_range(0, 1) == 1) begin
					send_code(CODE_CTRL);
					send_code(CODE_NUM);
					send_code(CODE_E1);
					send_code(REL_CTRL);
					send_code(CODE_NUM | 8'h80);
				end else begin
					repeat (5) send_code(8'($urandom_range(0, 255)));
				end
			end else begin
				send_code(8'($urandom_range(0, 255)));
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && words_due == 0)
			$display("scancode_set1_key_decoder test passed");
		else
			$display("scancode_set1_key_decoder test failed");
		$finish;
	end

endmodule
